// File: hdl/fts_pkg.sv
// Package for the frame time statistics block: field widths, reset values
// and the sequencer state type. No dependencies.
package fts_pkg;

  localparam int TICKS_W        = 32;
  localparam int RATE_W         = 32;
  localparam int TOTAL_W        = 64;
  localparam int COUNT_W        = 32;
  localparam int TPS_W          = 30;
  localparam int CFG_W          = 32;
  localparam int FRAC_W         = 8;
  localparam int OUT_W          = 7 * RATE_W + TOTAL_W + COUNT_W;
  localparam int DEFAULT_DEPTH  = 64;
  localparam int QUO_W          = 32;
  localparam int STEP_W         = 5;

  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000000);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_W - 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_UPDATE  = 7'b0000010,
    S_DIV_NOW = 7'b0000100,
    S_NOW_END = 7'b0001000,
    S_DIV_AVG = 7'b0010000,
    S_AVG_END = 7'b0100000,
    S_DONE    = 7'b1000000
  } fts_state_t;

endpackage

// File: hdl/frame_time_statistics_top.sv
// Frame time statistics: ring memory of recent durations, window sum, and a
// shared bit-serial divider for the rates. Depends on fts_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: frame_ticks
//  out_    | master    | out_tvalid/out_tready| out_tdata: nine statistics
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_data: ticks_per_second
//
// Each item passes through these steps: accept, a read-modify-write of the
// ring entry and window sum, the divider steps for the current rate (the
// average duration is formed alongside from three partial products with the
// reciprocal of the depth), a load of the window-rate division, the divider
// steps for the window rate, a close, and the hand-off of the result to
// the output register. The radix-2 divider dominates. The ring has no clearing
// pass: entries not yet written since reset read as zero until the ring
// position first wraps. Reset is synchronous. A result waiting in the output
// register does not block the next transfer in; a finished item waits in
// S_DONE only while the output register is still full.
module frame_time_statistics_top #(
  parameter int RING_DEPTH = fts_pkg::DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [31:0] frame_ticks
  input  logic [fts_pkg::TICKS_W-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [31:0] freq_now, [63:32] freq_window_avg, [95:64] freq_lowest,
  // [127:96] freq_highest, [159:128] ticks_window_avg, [191:160] ticks_lowest,
  // [223:192] ticks_highest, [287:224] ticks_total, [319:288] frames_total
  output logic [fts_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fts_pkg::CFG_W-1:0]   cfg_data
);

  localparam int AW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W   = fts_pkg::TICKS_W + $clog2(RING_DEPTH);
  localparam int DW      = $clog2(RING_DEPTH + 1);
  localparam int NUM_W   = fts_pkg::TPS_W + fts_pkg::FRAC_W + DW;
  localparam int CMP_W   = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int REM_W   = SUM_W;
  localparam logic [AW-1:0] POS_LAST = AW'(RING_DEPTH - 1);

  // Reciprocal of the depth, scaled so that the truncated product equals the
  // quotient for every window sum. It is applied one slice per cycle.
  localparam int RECIP_SH = SUM_W + $clog2(RING_DEPTH);
  localparam int CHUNK_W  = 16;
  localparam int CHUNKS   = (SUM_W + CHUNK_W) / CHUNK_W;
  localparam int RCP_W    = CHUNKS * CHUNK_W;
  localparam int ACC_W    = SUM_W + RCP_W;
  localparam int PROD_W   = SUM_W + CHUNK_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << RECIP_SH) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH);
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_WIDE);

  logic [fts_pkg::TICKS_W-1:0] ring_mem [RING_DEPTH];
  logic [fts_pkg::TICKS_W-1:0] ring_rd_r;

  fts_pkg::fts_state_t state_r, state_nxt;

  logic [fts_pkg::TPS_W-1:0]   tps_r;
  logic [fts_pkg::TICKS_W-1:0] dur_r;
  logic [AW-1:0]               pos_r;
  logic                        wrapped_r;
  logic [SUM_W-1:0]            sum_r;
  logic [fts_pkg::RATE_W-1:0]  rate_now_r, rate_avg_r, rate_min_r, rate_max_r;
  logic [fts_pkg::TICKS_W-1:0] shortest_r, longest_r, ticks_avg_r;
  logic [fts_pkg::TOTAL_W-1:0] elapsed_r;
  logic [fts_pkg::COUNT_W-1:0] frames_r;
  logic [NUM_W-1:0]            avg_num_r;

  // Shared divider for the rates.
  logic [REM_W-1:0]            rem_r;
  logic [SUM_W-1:0]            den_r;
  logic [fts_pkg::QUO_W-1:0]   quo_r;
  logic                        skip_r, sat_r;
  logic [fts_pkg::STEP_W-1:0]  step_r;

  // Product of the window sum and the reciprocal for the average duration.
  logic [ACC_W-1:0]            acc_r;

  logic                        out_valid_r;
  logic [fts_pkg::OUT_W-1:0]   out_data_r;

  logic                        in_xfer;
  logic [fts_pkg::TICKS_W-1:0] old_dur;
  logic [SUM_W-1:0]            sum_nxt;
  logic [NUM_W-1:0]            now_num;
  logic [fts_pkg::TOTAL_W:0]   elapsed_add;
  logic [REM_W:0]              trial;
  logic                        trial_ge;
  logic [REM_W-1:0]            rem_step;
  logic [CHUNK_W-1:0]          recip_chunk;
  logic [PROD_W-1:0]           part_prod;
  logic [ACC_W-1:0]            acc_nxt;
  logic [CMP_W-1:0]            now_hi, avg_hi;
  logic                        out_free;

  assign in_tready  = (state_r == fts_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Entries never written since reset count as zero.
  assign old_dur  = wrapped_r ? ring_rd_r : '0;
  assign sum_nxt  = sum_r - SUM_W'(old_dur) + SUM_W'(dur_r);
  assign now_num  = NUM_W'({tps_r, {fts_pkg::FRAC_W{1'b0}}});
  assign elapsed_add = {1'b0, elapsed_r} + (fts_pkg::TOTAL_W + 1)'(dur_r);
  assign now_hi   = CMP_W'(now_num >> fts_pkg::QUO_W);
  assign avg_hi   = CMP_W'(avg_num_r >> fts_pkg::QUO_W);

  assign trial     = {rem_r, quo_r[fts_pkg::QUO_W-1]};
  assign trial_ge  = trial >= {1'b0, den_r};
  assign rem_step  = trial_ge ? REM_W'(trial - {1'b0, den_r}) : REM_W'(trial);

  // The top slice of the reciprocal comes first, so the product builds up
  // by shifting the partial sum left one slice per step.
  always_comb begin
    recip_chunk = '0;
    for (int k = 0; k < CHUNKS; k++) begin
      if (step_r == fts_pkg::STEP_W'(CHUNKS - 1 - k)) begin
        recip_chunk = RECIP[k*CHUNK_W +: CHUNK_W];
      end
    end
  end

  assign part_prod = PROD_W'(sum_r) * PROD_W'(recip_chunk);
  assign acc_nxt   = {acc_r[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(part_prod);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fts_pkg::S_IDLE:    if (in_xfer) state_nxt = fts_pkg::S_UPDATE;
      fts_pkg::S_UPDATE:  state_nxt = fts_pkg::S_DIV_NOW;
      fts_pkg::S_DIV_NOW: if (step_r == fts_pkg::STEP_LAST) state_nxt = fts_pkg::S_NOW_END;
      fts_pkg::S_NOW_END: state_nxt = fts_pkg::S_DIV_AVG;
      fts_pkg::S_DIV_AVG: if (step_r == fts_pkg::STEP_LAST) state_nxt = fts_pkg::S_AVG_END;
      fts_pkg::S_AVG_END: state_nxt = fts_pkg::S_DONE;
      fts_pkg::S_DONE:    if (out_free) state_nxt = fts_pkg::S_IDLE;
      default:            state_nxt = fts_pkg::S_IDLE;
    endcase
  end

  // Ring memory: read at the input transfer, written back in the cycle after it.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ring_rd_r <= ring_mem[pos_r];
    end
    if (state_r == fts_pkg::S_UPDATE) begin
      ring_mem[pos_r] <= dur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fts_pkg::S_IDLE;
      tps_r       <= fts_pkg::TPS_RESET;
      pos_r       <= '0;
      wrapped_r   <= 1'b0;
      sum_r       <= '0;
      rate_now_r  <= '0;
      rate_avg_r  <= '0;
      rate_min_r  <= '1;
      rate_max_r  <= '0;
      shortest_r  <= '1;
      longest_r   <= '0;
      elapsed_r   <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        tps_r <= cfg_data[fts_pkg::TPS_W-1:0];
      end
      if (state_r == fts_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        fts_pkg::S_UPDATE: begin
          sum_r     <= sum_nxt;
          pos_r     <= (pos_r == POS_LAST) ? '0 : pos_r + AW'(1);
          wrapped_r <= wrapped_r || (pos_r == POS_LAST);
          elapsed_r <= elapsed_add[fts_pkg::TOTAL_W] ? '1 : elapsed_add[fts_pkg::TOTAL_W-1:0];
          if (frames_r != '1) frames_r <= frames_r + fts_pkg::COUNT_W'(1);
          if (dur_r < shortest_r) shortest_r <= dur_r;
          if (dur_r > longest_r) longest_r <= dur_r;
          step_r    <= '0;
        end
        fts_pkg::S_DIV_NOW, fts_pkg::S_DIV_AVG: begin
          step_r <= step_r + fts_pkg::STEP_W'(1);
        end
        fts_pkg::S_NOW_END: begin
          // A zero duration holds the previous rate.
          if (!skip_r) rate_now_r <= sat_r ? '1 : quo_r;
          step_r <= '0;
        end
        fts_pkg::S_AVG_END: begin
          if (!skip_r) rate_avg_r <= sat_r ? '1 : quo_r;
          if (rate_now_r < rate_min_r) rate_min_r <= rate_now_r;
          if (rate_now_r > rate_max_r) rate_max_r <= rate_now_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dur_r <= in_tdata;
    end
    case (state_r)
      fts_pkg::S_UPDATE: begin
        avg_num_r <= NUM_W'(tps_r) * NUM_W'(RING_DEPTH) << fts_pkg::FRAC_W;
        den_r     <= SUM_W'(dur_r);
        skip_r    <= (dur_r == '0);
        sat_r     <= now_hi >= CMP_W'(dur_r);
        rem_r     <= REM_W'(now_num >> fts_pkg::QUO_W);
        quo_r     <= now_num[fts_pkg::QUO_W-1:0];
        acc_r     <= '0;
      end
      fts_pkg::S_DIV_NOW: begin
        rem_r  <= rem_step;
        quo_r  <= {quo_r[fts_pkg::QUO_W-2:0], trial_ge};
        if (step_r < fts_pkg::STEP_W'(CHUNKS)) acc_r <= acc_nxt;
      end
      fts_pkg::S_NOW_END: begin
        ticks_avg_r <= acc_r[RECIP_SH +: fts_pkg::TICKS_W];
        den_r       <= sum_r;
        skip_r      <= (sum_r == '0);
        sat_r       <= avg_hi >= CMP_W'(sum_r);
        rem_r       <= REM_W'(avg_num_r >> fts_pkg::QUO_W);
        quo_r       <= avg_num_r[fts_pkg::QUO_W-1:0];
      end
      fts_pkg::S_DIV_AVG: begin
        rem_r <= rem_step;
        quo_r <= {quo_r[fts_pkg::QUO_W-2:0], trial_ge};
      end
      fts_pkg::S_DONE: begin
        if (out_free) begin
          out_data_r <= {frames_r, elapsed_r, longest_r, shortest_r, ticks_avg_r,
                         rate_max_r, rate_min_r, rate_avg_r, rate_now_r};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
